@@ src/jqc_pkg.sv @@
// ----------------------------------------------------------------------------
// jqc_pkg
// Shared types and constants of the job queue with cancel by key.
// ----------------------------------------------------------------------------
package jqc_pkg;

  localparam int unsigned DefaultDepth = 128;

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_CANCEL = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // One classified command handed from the front end to the back end.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] user_id;
    logic [15:0] page_count;
    logic [31:0] file_key;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] job_user;
    logic [15:0] job_pages;
    logic [31:0] job_file;
    logic [23:0] pages_waiting;
  } res_t;

endpackage

@@ src/job_queue_cancel_by_key.sv @@
// ----------------------------------------------------------------------------
// job_queue_cancel_by_key
// Job queue of fixed depth with push, pop and cancel by file key.
// ----------------------------------------------------------------------------
// Each input word is one command; each command yields exactly one result word,
// which also reports the pages still waiting. A small command queue in front
// accepts words while the back end works. The back end keeps the jobs packed
// in a single-port-per-side memory, oldest at address zero. A push writes the
// new job at the tail as it is taken; a pop or a cancel reads the entries from
// address zero, one read per step, until it hits, and then closes the gap by
// moving each later entry down with one read and one write, as the memory
// gives one read port and one write port.
// ----------------------------------------------------------------------------
module job_queue_cancel_by_key #(
  parameter int unsigned QUEUE_DEPTH = jqc_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind_i,
  input  logic [15:0] user_id_i,
  input  logic [15:0] page_count_i,
  input  logic [31:0] file_key_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [15:0] job_user_o,
  output logic [15:0] job_pages_o,
  output logic [31:0] job_file_o,
  output logic [23:0] pages_waiting_o
);
  import jqc_pkg::*;

  cmd_t in_cmd, cmd;
  res_t res;
  logic cmd_valid, cmd_take;

  assign in_cmd = '{kind: kind_e'(kind_i), user_id: user_id_i,
                    page_count: page_count_i, file_key: file_key_i};

  jqc_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .cmd_i(in_cmd),
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  jqc_back #(.Depth(QUEUE_DEPTH)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take), .cmd_i(cmd),
    .empty_o(empty), .pop_i(pop), .res_o(res)
  );

  assign status_o        = res.status;
  assign job_user_o      = res.job_user;
  assign job_pages_o     = res.job_pages;
  assign job_file_o      = res.job_file;
  assign pages_waiting_o = res.pages_waiting;

endmodule

@@ src/jqc_front.sv @@
// ----------------------------------------------------------------------------
// jqc_front
// Command queue: takes words from the input port and holds them for the back end.
// ----------------------------------------------------------------------------
module jqc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  jqc_pkg::cmd_t cmd_i,
  output logic          cmd_valid_o,
  input  logic          cmd_take_i,
  output jqc_pkg::cmd_t cmd_o
);
  import jqc_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_q];
  assign do_wr       = push_i && !full_o;
  assign do_rd       = cmd_take_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_wr) wr_q <= ~wr_q;
      if (do_rd) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("command queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |=> (cnt_q != 2'd2))
    else $error("command queue grew by two in one cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_rd && !do_wr |=> cnt_q == $past(cnt_q) - 2'd1)
    else $error("command queue count not decremented");

endmodule

@@ src/jqc_back.sv @@
// ----------------------------------------------------------------------------
// jqc_back
// Executes commands on the packed job store and holds one result word.
// ----------------------------------------------------------------------------
module jqc_back #(
  parameter int unsigned Depth = jqc_pkg::DefaultDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_take_o,
  input  jqc_pkg::cmd_t cmd_i,
  output logic          empty_o,
  input  logic          pop_i,
  output jqc_pkg::res_t res_o
);
  import jqc_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_CHECK, S_SHIFT_RD, S_SHIFT_WR, S_DONE
  } state_e;

  logic [15:0] mem_user  [Depth];
  logic [15:0] mem_pages [Depth];
  logic [31:0] mem_file  [Depth];

  state_e      state_q;
  cmd_t        cmd_q;
  logic [CW-1:0] count_q;
  logic [23:0] total_q;
  logic [CW-1:0] idx_q;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic [15:0] rd_user_q, rd_pages_q;
  logic [31:0] rd_file_q;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0] wr_user, wr_pages;
  logic [31:0] wr_file;
  res_t        res_q;
  logic        res_full_q;

  assign empty_o    = !res_full_q;
  assign res_o      = res_q;
  assign cmd_take_o = (state_q == S_IDLE) && cmd_valid_i && !res_full_q;

  // Read port: address follows the scan index; one read per cycle.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_q[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_q[AW-1:0];
    wr_user = rd_user_q;
    wr_pages = rd_pages_q;
    wr_file = rd_file_q;
    unique case (state_q)
      S_IDLE: begin
        rd_addr = '0;
        rd_en   = cmd_take_o;
        wr_addr = count_q[AW-1:0];
        wr_user = cmd_i.user_id;
        wr_pages = cmd_i.page_count;
        wr_file = cmd_i.file_key;
        wr_en   = cmd_take_o && (cmd_i.kind == KIND_PUSH) && (count_q != CW'(Depth));
      end
      S_SEARCH:   rd_en = 1'b1;
      S_SHIFT_RD: begin
        rd_addr = AW'(idx_q + CW'(1));
        rd_en   = 1'b1;
      end
      S_SHIFT_WR: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_user[wr_addr]  <= wr_user;
      mem_pages[wr_addr] <= wr_pages;
      mem_file[wr_addr]  <= wr_file;
    end
    if (rd_en) begin
      rd_user_q  <= mem_user[rd_addr];
      rd_pages_q <= mem_pages[rd_addr];
      rd_file_q  <= mem_file[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      total_q    <= '0;
      idx_q      <= '0;
      res_full_q <= 1'b0;
      cmd_q      <= '0;
      res_q      <= '0;
    end else begin
      if (pop_i && res_full_q) res_full_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cmd_take_o) begin
            cmd_q <= cmd_i;
            idx_q <= '0;
            res_q.job_user  <= '0;
            res_q.job_pages <= '0;
            res_q.job_file  <= '0;
            unique case (cmd_i.kind)
              KIND_PUSH: begin
                state_q <= S_DONE;
                if (count_q == CW'(Depth)) begin
                  res_q.status        <= ST_FULL;
                  res_q.pages_waiting <= total_q;
                end else begin
                  res_q.status        <= ST_OK;
                  count_q <= count_q + CW'(1);
                  total_q <= total_q + 24'(cmd_i.page_count);
                  res_q.pages_waiting <= total_q + 24'(cmd_i.page_count);
                end
              end
              KIND_POP, KIND_CANCEL: begin
                res_q.pages_waiting <= total_q;
                if (count_q == '0) begin
                  res_q.status <= ST_EMPTY;
                  state_q      <= S_DONE;
                end else begin
                  res_q.status <= ST_OK;
                  state_q      <= S_CHECK;
                end
              end
              default: begin
                res_q.status        <= ST_OK;
                res_q.pages_waiting <= total_q;
                state_q             <= S_DONE;
              end
            endcase
          end
        end
        S_SEARCH: state_q <= S_CHECK;
        S_CHECK: begin
          // Registered read data belongs to entry idx_q.
          if (cmd_q.kind == KIND_POP || rd_file_q == cmd_q.file_key) begin
            if (cmd_q.kind == KIND_POP) begin
              res_q.job_user  <= rd_user_q;
              res_q.job_pages <= rd_pages_q;
              res_q.job_file  <= rd_file_q;
            end
            total_q <= total_q - 24'(rd_pages_q);
            res_q.pages_waiting <= total_q - 24'(rd_pages_q);
            state_q <= S_SHIFT_RD;
          end else if (idx_q + CW'(1) >= count_q) begin
            res_q.status <= ST_NOTFOUND;
            state_q <= S_DONE;
          end else begin
            idx_q   <= idx_q + CW'(1);
            state_q <= S_SEARCH;
          end
        end
        S_SHIFT_RD: begin
          if (idx_q + CW'(1) >= count_q) begin
            count_q <= count_q - CW'(1);
            state_q <= S_DONE;
          end else begin
            state_q <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          idx_q   <= idx_q + CW'(1);
          state_q <= S_SHIFT_RD;
        end
        S_DONE: begin
          res_full_q <= 1'b1;
          state_q    <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(Depth))
    else $error("job count above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> !res_full_q || (pop_i))
    else $error("result produced while result register occupied");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT_RD || state_q == S_SHIFT_WR) |-> count_q != '0)
    else $error("shift on empty queue");

endmodule
